// ===== design/itf_pkg.sv =====
package itf_pkg;

	localparam int VALUE_BITS     = 32;
	localparam int MAX_FIELD      = 63;
	localparam int MAX_PREC       = MAX_FIELD - 3;
	localparam int DIGIT_SLOTS    = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam int FW_BITS        = 6;
	localparam int DIGIT_IDX_BITS = $clog2(DIGIT_SLOTS);
	localparam int ND_BITS        = $clog2(DIGIT_SLOTS + 1);
	localparam int COUNT_BITS     = FW_BITS + 1;
	localparam int QIDX_BITS      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

	// divide by ten: q = (x * RECIP10) >> RECIP10_SHIFT, exact for 32-bit x
	localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
	localparam int          RECIP10_SHIFT = 35;

	localparam int FLAG_ZEROPAD = 0;
	localparam int FLAG_SIGNED  = 1;
	localparam int FLAG_PLUS    = 2;
	localparam int FLAG_SPACE   = 3;
	localparam int FLAG_LEFT    = 4;
	localparam int FLAG_PREFIX  = 5;
	localparam int FLAG_UPPER   = 6;

	localparam logic [1:0] BASE_OCT = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	typedef enum logic [1:0] {
		RADIX_OCT,
		RADIX_DEC,
		RADIX_HEX
	} itf_radix_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] mag;
		itf_radix_t            radix;
		logic                  has_sign;
		logic [7:0]            sign_ch;
		logic [1:0]            prefix_len;
		logic                  upper;
		logic                  left;
		logic                  zpad;
		logic [FW_BITS-1:0]    width;
		logic [FW_BITS-1:0]    prec;
	} itf_job_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIG,
		BK_PLAN,
		BK_LEAD,
		BK_SIGN,
		BK_PFX0,
		BK_PFXX,
		BK_ZPAD,
		BK_PREC,
		BK_DIGS,
		BK_TRAIL
	} itf_back_state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base_ch;
		base_ch = upper ? CH_A_UP : CH_A_LO;
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'd0, d};
		else
			digit_char = base_ch + {4'd0, d} - 8'd10;
	endfunction

endpackage

// ===== design/itf_front.sv =====
module itf_front
	import itf_pkg::*;
(
	input  logic [VALUE_BITS-1:0] value,
	input  logic [1:0]            number_base,
	input  logic [FW_BITS-1:0]    total_width,
	input  logic [FW_BITS-1:0]    min_digits,
	input  logic [6:0]            format_flags,
	output itf_job_t              job
);

	logic neg;
	logic left;

	assign neg  = format_flags[FLAG_SIGNED] & value[VALUE_BITS-1];
	assign left = format_flags[FLAG_LEFT];

	always_comb begin
		job = '0;
		case (number_base)
			BASE_OCT: job.radix = RADIX_OCT;
			BASE_DEC: job.radix = RADIX_DEC;
			default:  job.radix = RADIX_HEX;
		endcase

		job.mag      = neg ? (VALUE_BITS'(0) - value) : value;
		job.has_sign = format_flags[FLAG_SIGNED] &
			(neg | format_flags[FLAG_PLUS] | format_flags[FLAG_SPACE]);
		if (neg)
			job.sign_ch = CH_MINUS;
		else if (format_flags[FLAG_PLUS])
			job.sign_ch = CH_PLUS;
		else
			job.sign_ch = CH_SPACE;

		if (!format_flags[FLAG_PREFIX])
			job.prefix_len = 2'd0;
		else if (job.radix == RADIX_HEX)
			job.prefix_len = 2'd2;
		else if (job.radix == RADIX_OCT)
			job.prefix_len = 2'd1;
		else
			job.prefix_len = 2'd0;

		job.upper = format_flags[FLAG_UPPER];
		job.left  = left;
		job.zpad  = format_flags[FLAG_ZEROPAD] & ~left;
		job.width = ({1'b0, total_width} > COUNT_BITS'(MAX_FIELD)) ?
			FW_BITS'(MAX_FIELD) : total_width;
		job.prec  = ({1'b0, min_digits} > COUNT_BITS'(MAX_PREC)) ?
			FW_BITS'(MAX_PREC) : min_digits;
	end

endmodule

// ===== design/itf_queue.sv =====
module itf_queue
	import itf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  itf_job_t wr_job,
	output logic     full,
	input  logic     pop,
	output itf_job_t rd_job,
	output logic     empty
);

	itf_job_t             mem_q [QUEUE_DEPTH];
	logic [QIDX_BITS-1:0] wr_ptr_q;
	logic [QIDX_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_job  = mem_q[rd_ptr_q];

	function automatic logic [QIDX_BITS-1:0] ptr_inc(input logic [QIDX_BITS-1:0] p);
		if (p == QIDX_BITS'(QUEUE_DEPTH - 1))
			ptr_inc = '0;
		else
			ptr_inc = p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

// ===== design/itf_back.sv =====
module itf_back
	import itf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  itf_job_t   job,
	input  logic       job_valid,
	output logic       job_take,
	output logic [7:0] char_code,
	output logic       last_char,
	output logic       empty,
	input  logic       pop
);

	itf_back_state_t          state_q, state_d;
	itf_job_t                 job_q;
	logic [VALUE_BITS-1:0]    mag_q, mag_d;
	logic [2*VALUE_BITS-1:0]  prod_q;
	logic [3:0]               digits_q [DIGIT_SLOTS];
	logic [ND_BITS-1:0]       nd_q, nd_d;
	logic [FW_BITS-1:0]       pad_q, pad_d;
	logic [FW_BITS-1:0]       zeros_q, zeros_d;
	logic [COUNT_BITS-1:0]    cnt_q, cnt_d;
	logic [COUNT_BITS-1:0]    left_q, left_d;
	logic                     ovalid_q, ovalid_d;
	logic [7:0]               char_q, char_d;
	logic                     last_q, last_d;
	logic                     dig_we;
	logic [3:0]               dig_rem;
	logic [VALUE_BITS-1:0]    dig_quo;
	logic                     out_free;

	assign empty     = ~ovalid_q;
	assign char_code = char_q;
	assign last_char = last_q;
	assign out_free  = ~ovalid_q | pop;

	// one digit per step, least significant first
	always_comb begin
		logic [VALUE_BITS-1:0] q10;
		logic [VALUE_BITS-1:0] r10;
		q10 = VALUE_BITS'(prod_q[2*VALUE_BITS-1:RECIP10_SHIFT]);
		r10 = mag_q - ((q10 << 3) + (q10 << 1));
		case (job_q.radix)
			RADIX_OCT: begin
				dig_rem = {1'b0, mag_q[2:0]};
				dig_quo = mag_q >> 3;
			end
			RADIX_DEC: begin
				dig_rem = r10[3:0];
				dig_quo = q10;
			end
			default: begin
				dig_rem = mag_q[3:0];
				dig_quo = mag_q >> 4;
			end
		endcase
	end

	function automatic itf_back_state_t next_phase(input itf_back_state_t s);
		case (s)
			BK_LEAD:  next_phase = BK_SIGN;
			BK_SIGN:  next_phase = BK_PFX0;
			BK_PFX0:  next_phase = BK_PFXX;
			BK_PFXX:  next_phase = BK_ZPAD;
			BK_ZPAD:  next_phase = BK_PREC;
			BK_PREC:  next_phase = BK_DIGS;
			BK_DIGS:  next_phase = BK_TRAIL;
			default:  next_phase = BK_IDLE;
		endcase
	endfunction

	function automatic logic [COUNT_BITS-1:0] phase_len(
		input itf_back_state_t    s,
		input itf_job_t           j,
		input logic [FW_BITS-1:0] pad,
		input logic [FW_BITS-1:0] zeros,
		input logic [ND_BITS-1:0] nd
	);
		case (s)
			BK_LEAD:  phase_len = (!j.zpad && !j.left) ? COUNT_BITS'(pad) : '0;
			BK_SIGN:  phase_len = COUNT_BITS'(j.has_sign);
			BK_PFX0:  phase_len = COUNT_BITS'(j.prefix_len != 2'd0);
			BK_PFXX:  phase_len = COUNT_BITS'(j.prefix_len == 2'd2);
			BK_ZPAD:  phase_len = j.zpad ? COUNT_BITS'(pad) : '0;
			BK_PREC:  phase_len = COUNT_BITS'(zeros);
			BK_DIGS:  phase_len = COUNT_BITS'(nd);
			BK_TRAIL: phase_len = j.left ? COUNT_BITS'(pad) : '0;
			default:  phase_len = '0;
		endcase
	endfunction

	always_comb begin
		logic [FW_BITS-1:0]        eff_prec;
		logic [COUNT_BITS-1:0]     lead_len;
		logic [COUNT_BITS-1:0]     wid_ext;
		logic [COUNT_BITS-1:0]     pad_ext;
		logic [7:0]                ch;
		logic [DIGIT_IDX_BITS-1:0] didx;
		itf_back_state_t           nxt;

		state_d  = state_q;
		mag_d    = mag_q;
		nd_d     = nd_q;
		pad_d    = pad_q;
		zeros_d  = zeros_q;
		cnt_d    = cnt_q;
		left_d   = left_q;
		ovalid_d = ovalid_q & ~pop;
		char_d   = char_q;
		last_d   = last_q;
		job_take = 1'b0;
		dig_we   = 1'b0;

		eff_prec = (job_q.prec > FW_BITS'(nd_q)) ? job_q.prec : FW_BITS'(nd_q);
		lead_len = {1'b0, eff_prec} + COUNT_BITS'(job_q.prefix_len) +
			COUNT_BITS'(job_q.has_sign);
		wid_ext  = {1'b0, job_q.width};
		pad_ext  = (wid_ext > lead_len) ? (wid_ext - lead_len) : '0;
		didx     = DIGIT_IDX_BITS'(cnt_q - 1'b1);
		nxt      = next_phase(state_q);

		case (state_q)
			BK_LEAD, BK_TRAIL:  ch = CH_SPACE;
			BK_SIGN:            ch = job_q.sign_ch;
			BK_PFXX:            ch = job_q.upper ? CH_X_UP : CH_X_LO;
			BK_DIGS:            ch = digit_char(digits_q[didx], job_q.upper);
			default:            ch = CH_ZERO;
		endcase

		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					mag_d    = job.mag;
					nd_d     = '0;
					state_d  = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_DIG;
			end
			BK_DIG: begin
				dig_we = 1'b1;
				nd_d   = nd_q + 1'b1;
				mag_d  = dig_quo;
				if (dig_quo == '0 || nd_q == ND_BITS'(DIGIT_SLOTS - 1))
					state_d = BK_PLAN;
				else
					state_d = BK_MUL;
			end
			BK_PLAN: begin
				pad_d   = FW_BITS'(pad_ext);
				zeros_d = eff_prec - FW_BITS'(nd_q);
				left_d  = pad_ext + lead_len;
				state_d = BK_LEAD;
				cnt_d   = phase_len(BK_LEAD, job_q, FW_BITS'(pad_ext),
					eff_prec - FW_BITS'(nd_q), nd_q);
			end
			BK_LEAD, BK_SIGN, BK_PFX0, BK_PFXX, BK_ZPAD, BK_PREC, BK_DIGS,
			BK_TRAIL: begin
				if (cnt_q == '0) begin
					state_d = nxt;
					cnt_d   = phase_len(nxt, job_q, pad_q, zeros_q, nd_q);
				end else if (out_free) begin
					ovalid_d = 1'b1;
					char_d   = ch;
					last_d   = (left_q == COUNT_BITS'(1));
					cnt_d    = cnt_q - 1'b1;
					left_d   = left_q - 1'b1;
					if (left_q == COUNT_BITS'(1))
						state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take)
			job_q <= job;
		mag_q   <= mag_d;
		prod_q  <= mag_q * RECIP10;
		nd_q    <= nd_d;
		pad_q   <= pad_d;
		zeros_q <= zeros_d;
		cnt_q   <= cnt_d;
		left_q  <= left_d;
		char_q  <= char_d;
		last_q  <= last_d;
		if (dig_we)
			digits_q[nd_q[DIGIT_IDX_BITS-1:0]] <= dig_rem;
	end

endmodule

// ===== design/integer_text_formatter.sv =====
// Formats one 32-bit integer as a printf-style text field and returns it one
// ASCII character per result, last_char set on the final one. A request is
// classified on entry and waits in a two-deep queue; the back end takes one
// request at a time: it takes the request, finds each digit through a multiply
// state and a digit state (octal, decimal via a reciprocal multiply, hex),
// plans the field, then walks the field sections and emits each character
// when the output is free or being popped. Up to two further requests are
// accepted while one is being formatted.
module integer_text_formatter
	import itf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [1:0]            number_base,
	input  logic [FW_BITS-1:0]    total_width,
	input  logic [FW_BITS-1:0]    min_digits,
	input  logic [6:0]            format_flags,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            char_code,
	output logic                  last_char
);

	itf_job_t front_job;
	itf_job_t queue_job;
	logic     queue_empty;
	logic     job_take;

	itf_front u_front (
		.value        (value),
		.number_base  (number_base),
		.total_width  (total_width),
		.min_digits   (min_digits),
		.format_flags (format_flags),
		.job          (front_job)
	);

	itf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (front_job),
		.full   (full),
		.pop    (job_take),
		.rd_job (queue_job),
		.empty  (queue_empty)
	);

	itf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queue_job),
		.job_valid (~queue_empty),
		.job_take  (job_take),
		.char_code (char_code),
		.last_char (last_char),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== design/itf_checker.sv =====
module itf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       pop,
	input logic       empty,
	input logic [7:0] char_code,
	input logic       last_char
);

	// requests accepted whose last character is not yet taken
	logic [2:0] open_q;
	logic       req_in;
	logic       req_done;

	assign req_in   = push & ~full;
	assign req_done = pop & ~empty & last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			if (req_in && !req_done)
				open_q <= open_q + 1'b1;
			else if (req_done && !req_in)
				open_q <= open_q - 1'b1;
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> open_q != 3'd0)
		else $error("result shown with no open request");

	a_open_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd4)
		else $error("too many open requests");

	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (char_code >= 8'h20 && char_code <= 8'h7A))
		else $error("non printable character");

	a_last_is_digit_or_space: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_char) |->
			(char_code == 8'h20 || (char_code >= 8'h30 && char_code <= 8'h39) ||
			 (char_code >= 8'h41 && char_code <= 8'h46) ||
			 (char_code >= 8'h61 && char_code <= 8'h66)))
		else $error("field ends on a bad character");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(char_code) && $stable(last_char)))
		else $error("waiting result changed");

endmodule

bind integer_text_formatter itf_checker u_itf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.pop       (pop),
	.empty     (empty),
	.char_code (char_code),
	.last_char (last_char)
);
